// ----- src/strided_slice_index_generator_macros.svh -----
// ----------------------------------------------------------------------------
// strided slice index generator assertion macros
// shared concurrent assertion forms, clocked on clk, quiet in reset
// ----------------------------------------------------------------------------
`ifndef STRIDED_SLICE_INDEX_GENERATOR_MACROS_SVH
`define STRIDED_SLICE_INDEX_GENERATOR_MACROS_SVH

// same-cycle implication
`define SSIG_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SSIG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/ssig_pkg.sv -----
// ----------------------------------------------------------------------------
// ssig_pkg
// widths, register indexes and parameter defaults of the slice index generator
// ----------------------------------------------------------------------------
package ssig_pkg;

	localparam int unsigned CNT_W     = 12;
	localparam int unsigned SID_W     = 25;
	localparam int unsigned CFG_IDX_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_W_START = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_W_END   = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_H_START = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_H_END   = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_C_START = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_C_END   = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_N_START = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_N_END   = 4'd7;

	localparam int unsigned DEF_DIM_H  = 64;
	localparam int unsigned DEF_DIM_C  = 64;
	localparam int unsigned DEF_STEP_W = 1;
	localparam int unsigned DEF_STEP_H = 1;
	localparam int unsigned DEF_STEP_C = 1;
	localparam int unsigned DEF_STEP_N = 1;

endpackage

// ----- src/ssig_ifs.sv -----
// ----------------------------------------------------------------------------
// ssig channel interfaces
// request, result and register write channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface ssig_req_if;
	import ssig_pkg::*;
	logic valid;
	logic ready;
	logic restart;
	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

interface ssig_rsp_if;
	import ssig_pkg::*;
	logic             valid;
	logic             ready;
	logic [SID_W-1:0] stick_id;
	logic [CNT_W-1:0] element_index;
	logic [CNT_W-1:0] out_position;
	logic             stick_last;
	logic             slice_last;
	modport source (output valid, output stick_id, output element_index,
		output out_position, output stick_last, output slice_last, input ready);
	modport sink (input valid, input stick_id, input element_index,
		input out_position, input stick_last, input slice_last, output ready);
endinterface

interface ssig_cfg_if;
	import ssig_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CNT_W-1:0]     data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- src/strided_slice_index_generator.sv -----
// ----------------------------------------------------------------------------
// strided_slice_index_generator: four-axis strided slice gather tuple walker
// a request word accepted while the walk is not exhausted has its result word in the cycle after
// throughput one word per cycle, set by the single result register freed by rsp.ready
// counter step, stick id and marks are formed in one pass ahead of the result register
// reset clears counters, config registers and result valid, walk waits for a restart request
// ----------------------------------------------------------------------------
`include "strided_slice_index_generator_macros.svh"

module strided_slice_index_generator #(
	parameter int unsigned DIM_H  = ssig_pkg::DEF_DIM_H,
	parameter int unsigned DIM_C  = ssig_pkg::DEF_DIM_C,
	parameter int unsigned STEP_W = ssig_pkg::DEF_STEP_W,
	parameter int unsigned STEP_H = ssig_pkg::DEF_STEP_H,
	parameter int unsigned STEP_C = ssig_pkg::DEF_STEP_C,
	parameter int unsigned STEP_N = ssig_pkg::DEF_STEP_N
) (
	input logic      clk,
	input logic      arst_n,
	ssig_req_if.sink   req,
	ssig_rsp_if.source rsp,
	ssig_cfg_if.sink   cfg
);
	import ssig_pkg::*;

	localparam logic [CNT_W:0]   STEP_W_V = (CNT_W+1)'(STEP_W);
	localparam logic [CNT_W:0]   STEP_H_V = (CNT_W+1)'(STEP_H);
	localparam logic [CNT_W:0]   STEP_C_V = (CNT_W+1)'(STEP_C);
	localparam logic [CNT_W:0]   STEP_N_V = (CNT_W+1)'(STEP_N);
	localparam logic [SID_W-1:0] MUL_C    = SID_W'(DIM_H);
	localparam logic [SID_W-1:0] MUL_N    = SID_W'(DIM_C * DIM_H);

	// configuration registers
	logic [CNT_W-1:0] w_start_q, w_end_q, h_start_q, h_end_q;
	logic [CNT_W-1:0] c_start_q, c_end_q, n_start_q, n_end_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_start_q <= '0;
			w_end_q   <= '0;
			h_start_q <= '0;
			h_end_q   <= '0;
			c_start_q <= '0;
			c_end_q   <= '0;
			n_start_q <= '0;
			n_end_q   <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_W_START: w_start_q <= cfg.data;
				REG_W_END:   w_end_q   <= cfg.data;
				REG_H_START: h_start_q <= cfg.data;
				REG_H_END:   h_end_q   <= cfg.data;
				REG_C_START: c_start_q <= cfg.data;
				REG_C_END:   c_end_q   <= cfg.data;
				REG_N_START: n_start_q <= cfg.data;
				REG_N_END:   n_end_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	// walk state
	logic [CNT_W-1:0] w_count_q, h_count_q, c_count_q, n_count_q, out_count_q;
	logic             exhausted_q;

	// result valid and advance
	logic v_s1;
	logic adv1, acc;

	assign adv1      = !v_s1 || rsp.ready;
	assign req.ready = adv1;
	assign acc       = req.valid && adv1;

	// step logic
	logic [CNT_W-1:0] cur_w, cur_h, cur_c, cur_n, cur_out;
	logic [CNT_W:0]   nw, nh, nc, nn;
	logic             empty, exh, emit, w_done, h_done, c_done, n_done;
	logic [SID_W-1:0] sid;
	logic [CNT_W-1:0] w_nx, h_nx, c_nx, n_nx, out_nx;
	logic             exh_nx;

	always_comb begin
		empty   = !(w_start_q < w_end_q) || !(h_start_q < h_end_q) ||
			!(c_start_q < c_end_q) || !(n_start_q < n_end_q);
		cur_w   = req.restart ? w_start_q : w_count_q;
		cur_h   = req.restart ? h_start_q : h_count_q;
		cur_c   = req.restart ? c_start_q : c_count_q;
		cur_n   = req.restart ? n_start_q : n_count_q;
		cur_out = req.restart ? '0 : out_count_q;
		exh     = req.restart ? empty : exhausted_q;
		emit    = !exh;
		nw      = {1'b0, cur_w} + STEP_W_V;
		nh      = {1'b0, cur_h} + STEP_H_V;
		nc      = {1'b0, cur_c} + STEP_C_V;
		nn      = {1'b0, cur_n} + STEP_N_V;
		w_done  = !(nw < {1'b0, w_end_q});
		h_done  = w_done && !(nh < {1'b0, h_end_q});
		c_done  = h_done && !(nc < {1'b0, c_end_q});
		n_done  = c_done && !(nn < {1'b0, n_end_q});
		sid     = {{(SID_W-CNT_W){1'b0}}, cur_h} +
			({{(SID_W-CNT_W){1'b0}}, cur_c} * MUL_C) +
			({{(SID_W-CNT_W){1'b0}}, cur_n} * MUL_N);
	end

	always_comb begin
		w_nx   = w_count_q;
		h_nx   = h_count_q;
		c_nx   = c_count_q;
		n_nx   = n_count_q;
		out_nx = out_count_q;
		exh_nx = exhausted_q;
		if (acc) begin
			w_nx   = cur_w;
			h_nx   = cur_h;
			c_nx   = cur_c;
			n_nx   = cur_n;
			out_nx = cur_out;
			exh_nx = exh;
			if (emit) begin
				if (!w_done) begin
					w_nx   = nw[CNT_W-1:0];
					out_nx = cur_out + CNT_W'(1);
				end else begin
					w_nx   = w_start_q;
					out_nx = '0;
					if (!h_done) begin
						h_nx = nh[CNT_W-1:0];
					end else begin
						h_nx = h_start_q;
						if (!c_done) begin
							c_nx = nc[CNT_W-1:0];
						end else begin
							c_nx = c_start_q;
							if (!n_done) begin
								n_nx = nn[CNT_W-1:0];
							end else begin
								n_nx   = n_start_q;
								exh_nx = 1'b1;
							end
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_count_q   <= '0;
			h_count_q   <= '0;
			c_count_q   <= '0;
			n_count_q   <= '0;
			out_count_q <= '0;
			exhausted_q <= 1'b1;
		end else begin
			w_count_q   <= w_nx;
			h_count_q   <= h_nx;
			c_count_q   <= c_nx;
			n_count_q   <= n_nx;
			out_count_q <= out_nx;
			exhausted_q <= exh_nx;
		end
	end

	// result register
	logic [SID_W-1:0] sid_s1;
	logic [CNT_W-1:0] w_s1, out_s1;
	logic             wl_s1, sl_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= acc && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			sid_s1 <= sid;
			w_s1   <= cur_w;
			out_s1 <= cur_out;
			wl_s1  <= w_done;
			sl_s1  <= n_done;
		end
	end

	assign rsp.valid         = v_s1;
	assign rsp.stick_id      = sid_s1;
	assign rsp.element_index = w_s1;
	assign rsp.out_position  = out_s1;
	assign rsp.stick_last    = wl_s1;
	assign rsp.slice_last    = sl_s1;

	`SSIG_ASSERT_NEXT(a_last_exhausts, acc && emit && n_done, exhausted_q, "walk not exhausted after last word")
	`SSIG_ASSERT_NEXT(a_wrap_clears_pos, acc && emit && w_done, out_count_q == '0, "out position not cleared at stick end")
	`SSIG_ASSERT_NEXT(a_no_word_when_done, acc && !emit, !v_s1, "word issued from exhausted walk")
	`SSIG_ASSERT_SAME(a_slice_ends_stick, rsp.valid && rsp.slice_last, rsp.stick_last, "slice end without stick end")

endmodule
